### rtl/lidar_sector_obstacle_avoider_macros.svh
// Assertion macros shared by the checker files of the obstacle avoider.
// Plain text macros only; no dependencies.
`ifndef LIDAR_SECTOR_OBSTACLE_AVOIDER_MACROS_SVH
`define LIDAR_SECTOR_OBSTACLE_AVOIDER_MACROS_SVH

// Check cons in the same cycle that ante holds.
`define LSOA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsoa: same-cycle check failed");

// Check cons in the cycle after ante holds.
`define LSOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsoa: next-cycle check failed");

`endif

### rtl/lsoa_pkg.sv
// Types, codes and constants of the lidar sector obstacle avoider.
// No dependencies; used by the top level and its checker.
`default_nettype none

package lsoa_pkg;

    localparam int RANGE_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF = 8;

    localparam int FIELD_W     = 16;   // range and threshold fields
    localparam int START_W     = 13;
    localparam int STEP_W      = 10;
    localparam int TICKS_W     = 8;
    localparam int ANGLE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;
    localparam int MIN_INIT_MM = 2000;

    localparam logic [FIELD_W-1:0] VALID_MIN_RST   = 16'd100;
    localparam logic [FIELD_W-1:0] VALID_MAX_RST   = 16'd30000;
    localparam logic [FIELD_W-1:0] CLEAR_RST       = 16'd1150;
    localparam logic [FIELD_W-1:0] FRONT_DELTA_RST = 16'd150;
    localparam logic [START_W-1:0] START_ANGLE_RST = 13'h13BA; // -3142
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 10'd10;
    localparam logic [TICKS_W-1:0] ESCAPE_RST      = 8'd30;
    localparam logic [TICKS_W-1:0] AVOID_RST       = 8'd10;

    typedef enum logic [1:0] {
        ROBOT_DRIVING  = 2'd0,
        ROBOT_AVOIDING = 2'd1,
        ROBOT_ESCAPING = 2'd2,
        ROBOT_MANUAL   = 2'd3
    } robot_mode_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_MANUAL = 2'd2
    } item_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VALID_MIN   = 3'd0,
        REG_VALID_MAX   = 3'd1,
        REG_CLEAR       = 3'd2,
        REG_FRONT_DELTA = 3'd3,
        REG_START_ANGLE = 3'd4,
        REG_ANGLE_STEP  = 3'd5,
        REG_ESCAPE      = 3'd6,
        REG_AVOID       = 3'd7
    } cfg_reg_t;

    localparam logic [2:0] CLASS_CLEAR = 3'd0;
    localparam logic [2:0] CLASS_FRONT = 3'd1;
    localparam logic [2:0] CLASS_RIGHT = 3'd2;
    localparam logic [2:0] CLASS_LEFT  = 3'd3;
    localparam logic [2:0] CLASS_NONE  = 3'd4;

    localparam logic [1:0] TURN_NONE = 2'b00;
    localparam logic [1:0] TURN_CCW  = 2'b01;
    localparam logic [1:0] TURN_CW   = 2'b11;

    // Input item payload, lowest bits last in the declaration.
    typedef struct packed {
        logic [S_TDATA_W-FIELD_W-3:0] pad;
        logic                         key_moving;
        logic                         range_valid;
        logic [FIELD_W-1:0]           range_mm;
    } in_data_t;

    // Result item payload, lowest bits last in the declaration.
    typedef struct packed {
        logic [2:0]  obstacle_class;
        logic        drive_forward;
        logic [1:0]  turn_direction;
        robot_mode_t robot_mode;
    } result_t;

endpackage

`default_nettype wire

### rtl/lidar_sector_obstacle_avoider.sv
// Lidar sector obstacle avoider: per-side minimum tracking, scan
// classification and a timed-rotation mode machine. Depends on lsoa_pkg.
//
// Usage:
//   s_ channel: one item per handshake. s_tuser is the item kind (sample,
//   tick, manual event), s_tlast marks the final sample of a scan and
//   s_tdata carries range, range-valid flag and manual key state.
//   m_ channel: exactly one result item per input item, in order: robot
//   mode, turn command, forward flag and the scan class (4 = none).
//   cfg_ channel: register writes, always ready. Write
//   only while no item is in flight; writing the start angle also reloads
//   the angle accumulator.
// Result: registered; one item per cycle while s_tready is high. The whole
//   item update (threshold compares, minimum update, angle add,
//   classification, mode and timer update) sits between the state registers
//   and the result register.
// Stall: a two-entry output stage (result register plus skid) keeps the
//   input ready while one result waits; s_tready drops only when both hold.
// Reset: synchronous, active low. Config registers return to their defaults,
//   mode goes to driving, minima to 2000 mm, timer and turn clear, the
//   accumulator loads the start angle and the output stage empties.
`default_nettype none

module lidar_sector_obstacle_avoider #(
    parameter int RANGE_BITS = lsoa_pkg::RANGE_BITS_DEF,
    parameter int TIMER_BITS = lsoa_pkg::TIMER_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input item channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata from bit 0: range_mm[15:0], range_valid, key_moving, zero pad
    input  wire logic [lsoa_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser from bit 0: kind[1:0]
    input  wire logic [1:0]                       s_tuser,
    input  wire logic                             s_tlast,   // last_sample
    // Result item channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata from bit 0: robot_mode[1:0], turn_direction[1:0],
    // drive_forward, obstacle_class[2:0]
    output logic [lsoa_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lsoa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lsoa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsoa_pkg::*;

    // Compare width covers both the range registers and the 16-bit thresholds.
    localparam int CMP_W = (RANGE_BITS > FIELD_W) ? RANGE_BITS : FIELD_W;
    localparam int RANGE_FULL = (2 ** RANGE_BITS) - 1;
    localparam logic [RANGE_BITS-1:0] MIN_INIT =
        RANGE_BITS'((RANGE_FULL < MIN_INIT_MM) ? RANGE_FULL : MIN_INIT_MM);

    // Configuration registers
    logic [FIELD_W-1:0]    valid_min_reg, valid_max_reg, clear_reg, front_delta_reg;
    logic [START_W-1:0]    start_angle_reg;
    logic [STEP_W-1:0]     angle_step_reg;
    logic [TICKS_W-1:0]    escape_ticks_reg, avoid_ticks_reg;

    // Block state
    robot_mode_t           mode_reg, mode_next;
    logic [RANGE_BITS-1:0] left_min_reg, left_min_next;
    logic [RANGE_BITS-1:0] right_min_reg, right_min_next;
    logic [ANGLE_W-1:0]    angle_acc_reg, angle_acc_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [1:0]            rotate_dir_reg, rotate_dir_next;

    // Output stage
    result_t               out_reg, out_next, skid_reg, skid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;

    in_data_t              in_data;
    logic                  accept;
    logic [RANGE_BITS-1:0] range_r;
    logic [CMP_W-1:0]      range_c;
    logic                  active;
    logic                  sample_ok;
    logic [RANGE_BITS-1:0] upd_left, upd_right;
    logic [RANGE_BITS-1:0] diff;
    logic [ANGLE_W-1:0]    start_ext;
    logic [TIMER_BITS-1:0] escape_t, avoid_t;
    logic [2:0]            cls;
    result_t               result;

    assign in_data   = in_data_t'(s_tdata);
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_reg);

    assign range_r   = RANGE_BITS'(in_data.range_mm);
    assign range_c   = CMP_W'(range_r);
    assign start_ext = {{(ANGLE_W-START_W){start_angle_reg[START_W-1]}}, start_angle_reg};
    assign escape_t  = TIMER_BITS'(escape_ticks_reg);
    assign avoid_t   = TIMER_BITS'(avoid_ticks_reg);

    // Scans count only in driving or avoiding with no rotation running.
    assign active = ((mode_reg == ROBOT_DRIVING) || (mode_reg == ROBOT_AVOIDING))
                    && (timer_reg == '0);
    assign sample_ok = active && in_data.range_valid
                       && (range_c > CMP_W'(valid_min_reg))
                       && (range_c < CMP_W'(valid_max_reg));

    // Negative angle feeds the right side, positive the left, zero neither.
    always_comb begin
        upd_left  = left_min_reg;
        upd_right = right_min_reg;
        if (sample_ok) begin
            if (angle_acc_reg[ANGLE_W-1]) begin
                if (range_r < right_min_reg) begin
                    upd_right = range_r;
                end
            end else if (angle_acc_reg != '0) begin
                if (range_r < left_min_reg) begin
                    upd_left = range_r;
                end
            end
        end
    end

    assign diff = (upd_right > upd_left) ? (upd_right - upd_left) : (upd_left - upd_right);

    // Next state and result for the accepted item
    always_comb begin
        mode_next       = mode_reg;
        left_min_next   = left_min_reg;
        right_min_next  = right_min_reg;
        angle_acc_next  = angle_acc_reg;
        timer_next      = timer_reg;
        rotate_dir_next = rotate_dir_reg;
        cls             = CLASS_NONE;
        if (accept) begin
            unique case (item_kind_t'(s_tuser))
                KIND_SAMPLE: begin
                    left_min_next  = upd_left;
                    right_min_next = upd_right;
                    angle_acc_next = angle_acc_reg + ANGLE_W'(angle_step_reg);
                    if (s_tlast) begin
                        if (active) begin
                            if ((CMP_W'(upd_left) > CMP_W'(clear_reg))
                                    && (CMP_W'(upd_right) > CMP_W'(clear_reg))) begin
                                cls = CLASS_CLEAR;
                                if (mode_reg == ROBOT_AVOIDING) begin
                                    mode_next = ROBOT_DRIVING;
                                end
                            end else if (CMP_W'(diff) < CMP_W'(front_delta_reg)) begin
                                // Front: escape; a zero-length turn drives on at once.
                                cls        = CLASS_FRONT;
                                timer_next = escape_t;
                                if (escape_t == '0) begin
                                    mode_next       = ROBOT_DRIVING;
                                    rotate_dir_next = TURN_NONE;
                                end else begin
                                    mode_next       = ROBOT_ESCAPING;
                                    rotate_dir_next = TURN_CCW;
                                end
                            end else begin
                                mode_next  = ROBOT_AVOIDING;
                                timer_next = avoid_t;
                                if (upd_right < upd_left) begin
                                    cls             = CLASS_RIGHT;
                                    rotate_dir_next = (avoid_t == '0) ? TURN_NONE : TURN_CCW;
                                end else begin
                                    cls             = CLASS_LEFT;
                                    rotate_dir_next = (avoid_t == '0) ? TURN_NONE : TURN_CW;
                                end
                            end
                        end
                        // Rearm for the next scan
                        left_min_next  = MIN_INIT;
                        right_min_next = MIN_INIT;
                        angle_acc_next = start_ext;
                    end
                end
                KIND_TICK: begin
                    if (timer_reg != '0) begin
                        timer_next = timer_reg - 1'b1;
                        if (timer_reg == TIMER_BITS'(1)) begin
                            rotate_dir_next = TURN_NONE;
                            if (mode_reg == ROBOT_ESCAPING) begin
                                mode_next = ROBOT_DRIVING;
                            end
                        end
                    end
                end
                KIND_MANUAL: begin
                    mode_next       = in_data.key_moving ? ROBOT_MANUAL : ROBOT_DRIVING;
                    timer_next      = '0;
                    rotate_dir_next = TURN_NONE;
                end
                default: begin
                    // unused kind: hold everything
                end
            endcase
        end

        // A start angle write reloads the accumulator.
        if (cfg_valid && cfg_ready && (cfg_reg_t'(cfg_index) == REG_START_ANGLE)) begin
            angle_acc_next = {{(ANGLE_W-START_W){cfg_data[START_W-1]}},
                              cfg_data[START_W-1:0]};
        end

        result.robot_mode     = mode_next;
        result.turn_direction = (timer_next != '0) ? rotate_dir_next : TURN_NONE;
        result.drive_forward  = (mode_next == ROBOT_DRIVING) && (timer_next == '0);
        result.obstacle_class = cls;
    end

    // Output register plus skid entry
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = accept;
            end
        end else if (accept) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_min_reg    <= VALID_MIN_RST;
            valid_max_reg    <= VALID_MAX_RST;
            clear_reg        <= CLEAR_RST;
            front_delta_reg  <= FRONT_DELTA_RST;
            start_angle_reg  <= START_ANGLE_RST;
            angle_step_reg   <= ANGLE_STEP_RST;
            escape_ticks_reg <= ESCAPE_RST;
            avoid_ticks_reg  <= AVOID_RST;
            mode_reg         <= ROBOT_DRIVING;
            left_min_reg     <= MIN_INIT;
            right_min_reg    <= MIN_INIT;
            angle_acc_reg    <= {{(ANGLE_W-START_W){START_ANGLE_RST[START_W-1]}},
                                 START_ANGLE_RST};
            timer_reg        <= '0;
            rotate_dir_reg   <= TURN_NONE;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            left_min_reg   <= left_min_next;
            right_min_reg  <= right_min_next;
            angle_acc_reg  <= angle_acc_next;
            timer_reg      <= timer_next;
            rotate_dir_reg <= rotate_dir_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_VALID_MIN:   valid_min_reg    <= cfg_data[FIELD_W-1:0];
                    REG_VALID_MAX:   valid_max_reg    <= cfg_data[FIELD_W-1:0];
                    REG_CLEAR:       clear_reg        <= cfg_data[FIELD_W-1:0];
                    REG_FRONT_DELTA: front_delta_reg  <= cfg_data[FIELD_W-1:0];
                    REG_START_ANGLE: start_angle_reg  <= cfg_data[START_W-1:0];
                    REG_ANGLE_STEP:  angle_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_ESCAPE:      escape_ticks_reg <= cfg_data[TICKS_W-1:0];
                    REG_AVOID:       avoid_ticks_reg  <= cfg_data[TICKS_W-1:0];
                endcase
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

### rtl/lsoa_checker.sv
// Port-level checker for the obstacle avoider, bound to the top level.
// Depends on lsoa_pkg and lidar_sector_obstacle_avoider_macros.svh.
`default_nettype none
`include "lidar_sector_obstacle_avoider_macros.svh"

module lsoa_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lsoa_pkg::M_TDATA_W-1:0] m_tdata
);
    import lsoa_pkg::*;

    result_t res;
    assign res = result_t'(m_tdata);

    // A stalled result holds
    `LSOA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Forward drive only in driving mode with no turn
    `LSOA_ASSERT_SAME(a_fwd_no_turn, aclk, aresetn, m_tvalid && res.drive_forward, res.robot_mode == ROBOT_DRIVING && res.turn_direction == TURN_NONE)
    // Turn command is one of the three legal codes
    `LSOA_ASSERT_SAME(a_turn_code, aclk, aresetn, m_tvalid, res.turn_direction == TURN_NONE || res.turn_direction == TURN_CCW || res.turn_direction == TURN_CW)
    // Manual mode never turns and never classifies
    `LSOA_ASSERT_SAME(a_manual_quiet, aclk, aresetn, m_tvalid && res.robot_mode == ROBOT_MANUAL, res.turn_direction == TURN_NONE && res.obstacle_class == CLASS_NONE)
    // With the output stage empty the input is open
    `LSOA_ASSERT_SAME(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready)

endmodule

bind lidar_sector_obstacle_avoider lsoa_checker u_lsoa_checker (.*);

`default_nettype wire

### sim/lidar_sector_obstacle_avoider_checker.sv
// Checker for the obstacle avoider: watches the input, result and register channels,
// predicts each result item and compares it field by field. Depends on lsoa_pkg.
`timescale 1ns / 100ps

module lidar_sector_obstacle_avoider_checker
    import lsoa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    // Register copies
    logic [FIELD_W-1:0] vmin_mm, vmax_mm, clear_thr_mm, front_thr_mm;
    logic [START_W-1:0] start_mrad;
    logic [STEP_W-1:0]  step_mrad;
    logic [TICKS_W-1:0] escape_len, avoid_len;

    // Avoider state copies
    robot_mode_t        drive_mode;
    logic [FIELD_W-1:0] left_min_mm, right_min_mm;
    logic [ANGLE_W-1:0] angle_acc;
    logic [TICKS_W-1:0] turn_timer;
    logic [1:0]         turn_dir;

    result_t expected_commands[$];
    int      results_seen;

    function automatic logic [ANGLE_W-1:0] start_angle16();
        return {{(ANGLE_W-START_W){start_mrad[START_W-1]}}, start_mrad};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic begin_turn(input logic [TICKS_W-1:0] ticks, input logic [1:0] dir);
        turn_timer = ticks;
        if (ticks == '0) begin
            turn_dir = TURN_NONE;
            if (drive_mode == ROBOT_ESCAPING)
                drive_mode = ROBOT_DRIVING;
        end else begin
            turn_dir = dir;
        end
    endtask

    // Advance the avoider by one item and return the command it produces.
    task automatic predict_command(input logic [1:0] kind, input in_data_t item,
                                   input logic last, output result_t cmd);
        logic               scan_live;
        logic [FIELD_W-1:0] gap_mm;
        logic [2:0]         verdict;
        verdict = CLASS_NONE;
        case (kind)
            KIND_SAMPLE: begin
                scan_live = (drive_mode == ROBOT_DRIVING || drive_mode == ROBOT_AVOIDING)
                            && turn_timer == '0;
                if (scan_live && item.range_valid && item.range_mm > vmin_mm
                        && item.range_mm < vmax_mm) begin
                    if (angle_acc[ANGLE_W-1]) begin
                        if (item.range_mm < right_min_mm)
                            right_min_mm = item.range_mm;
                    end else if (angle_acc != '0) begin
                        if (item.range_mm < left_min_mm)
                            left_min_mm = item.range_mm;
                    end
                end
                angle_acc = angle_acc + ANGLE_W'(step_mrad);
                if (last) begin
                    if (scan_live) begin
                        gap_mm = (right_min_mm > left_min_mm) ? right_min_mm - left_min_mm
                                                              : left_min_mm - right_min_mm;
                        if (left_min_mm > clear_thr_mm && right_min_mm > clear_thr_mm) begin
                            verdict = CLASS_CLEAR;
                            if (drive_mode == ROBOT_AVOIDING)
                                drive_mode = ROBOT_DRIVING;
                        end else if (gap_mm < front_thr_mm) begin
                            verdict    = CLASS_FRONT;
                            drive_mode = ROBOT_ESCAPING;
                            begin_turn(escape_len, TURN_CCW);
                        end else begin
                            drive_mode = ROBOT_AVOIDING;
                            if (right_min_mm < left_min_mm) begin
                                verdict = CLASS_RIGHT;
                                begin_turn(avoid_len, TURN_CCW);
                            end else begin
                                verdict = CLASS_LEFT;
                                begin_turn(avoid_len, TURN_CW);
                            end
                        end
                    end
                    left_min_mm  = FIELD_W'(MIN_INIT_MM);
                    right_min_mm = FIELD_W'(MIN_INIT_MM);
                    angle_acc    = start_angle16();
                end
            end
            KIND_TICK: begin
                if (turn_timer != '0) begin
                    turn_timer = turn_timer - 1'b1;
                    if (turn_timer == '0) begin
                        turn_dir = TURN_NONE;
                        if (drive_mode == ROBOT_ESCAPING)
                            drive_mode = ROBOT_DRIVING;
                    end
                end
            end
            KIND_MANUAL: begin
                drive_mode = item.key_moving ? ROBOT_MANUAL : ROBOT_DRIVING;
                turn_timer = '0;
                turn_dir   = TURN_NONE;
            end
            default: ;  // unused kind: nothing moves
        endcase
        cmd.robot_mode     = drive_mode;
        cmd.turn_direction = (turn_timer != '0) ? turn_dir : TURN_NONE;
        cmd.drive_forward  = (drive_mode == ROBOT_DRIVING && turn_timer == '0);
        cmd.obstacle_class = verdict;
    endtask

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            vmin_mm      = VALID_MIN_RST;
            vmax_mm      = VALID_MAX_RST;
            clear_thr_mm = CLEAR_RST;
            front_thr_mm = FRONT_DELTA_RST;
            start_mrad   = START_ANGLE_RST;
            step_mrad    = ANGLE_STEP_RST;
            escape_len   = ESCAPE_RST;
            avoid_len    = AVOID_RST;
            drive_mode   = ROBOT_DRIVING;
            left_min_mm  = FIELD_W'(MIN_INIT_MM);
            right_min_mm = FIELD_W'(MIN_INIT_MM);
            angle_acc    = start_angle16();
            turn_timer   = '0;
            turn_dir     = TURN_NONE;
            expected_commands.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VALID_MIN:   vmin_mm      = cfg_data;
                    REG_VALID_MAX:   vmax_mm      = cfg_data;
                    REG_CLEAR:       clear_thr_mm = cfg_data;
                    REG_FRONT_DELTA: front_thr_mm = cfg_data;
                    REG_START_ANGLE: begin
                        start_mrad = cfg_data[START_W-1:0];
                        angle_acc  = start_angle16();
                    end
                    REG_ANGLE_STEP:  step_mrad  = cfg_data[STEP_W-1:0];
                    REG_ESCAPE:      escape_len = cfg_data[TICKS_W-1:0];
                    REG_AVOID:       avoid_len  = cfg_data[TICKS_W-1:0];
                    default: ;
                endcase
            end
            // Compare before predicting: a result never belongs to the item taken
            // at the same edge.
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_commands.size() == 0) begin
                    report_mismatch("result with no item waiting", m_tdata, -1);
                end else begin
                    want = expected_commands.pop_front();
                    if (got.robot_mode != want.robot_mode)
                        report_mismatch("robot_mode", got.robot_mode, want.robot_mode);
                    if (got.turn_direction != want.turn_direction)
                        report_mismatch("turn_direction", got.turn_direction,
                                        want.turn_direction);
                    if (got.drive_forward != want.drive_forward)
                        report_mismatch("drive_forward", got.drive_forward,
                                        want.drive_forward);
                    if (got.obstacle_class != want.obstacle_class)
                        report_mismatch("obstacle_class", got.obstacle_class,
                                        want.obstacle_class);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                predict_command(s_tuser, in_data_t'(s_tdata), s_tlast, want);
                expected_commands.push_back(want);
            end
        end
        pending = expected_commands.size();
    end

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

endmodule

### sim/lidar_sector_obstacle_avoider_tb.sv
// Testbench top for the lidar sector obstacle avoider: drives items and register
// writes, stalls the result side and prints the verdict. Depends on lsoa_pkg and
// lidar_sector_obstacle_avoider_checker.
`timescale 1ns / 100ps

module lidar_sector_obstacle_avoider_tb;
    import lsoa_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;     // long result-side hold-off
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_PHASES    = 7;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid, s_tready, s_tlast;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid, m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid, cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count, pending;

    // Stimulus bookkeeping shared by the sender, the receiver and the main flow
    int   items_sent;
    int   tx_run, tx_rush, rx_run;
    logic tx_lazy, rx_lazy;
    logic hold_request;
    int   tick_burst_max;
    logic [FIELD_W-1:0] cur_vmin, cur_vmax;

    lidar_sector_obstacle_avoider i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lidar_sector_obstacle_avoider_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Result side: draw a stall per item, in runs of busy and idle-free stretches.
    // When asked, hold off for a long stretch so the output stage fills and the
    // block drops s_tready while the sender keeps offering items.
    initial begin
        int stall;
        m_tready = 1'b0;
        rx_run   = 0;
        rx_lazy  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                if (rx_run == 0) begin
                    rx_run  = $urandom_range(5, 60);
                    rx_lazy = ($urandom_range(0, 2) != 0);
                end
                rx_run--;
                stall = rx_lazy ? $urandom_range(0, 12) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            // advance once this result item is taken
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Write one register; inputs change on the falling edge only.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int vmin, input int vmax, input int clear_mm,
                                 input int front_mm, input int start_mrad,
                                 input int step_mrad, input int esc, input int avd);
        write_reg(REG_VALID_MIN,   16'(vmin));
        write_reg(REG_VALID_MAX,   16'(vmax));
        write_reg(REG_CLEAR,       16'(clear_mm));
        write_reg(REG_FRONT_DELTA, 16'(front_mm));
        write_reg(REG_START_ANGLE, 16'(start_mrad));
        write_reg(REG_ANGLE_STEP,  16'(step_mrad));
        write_reg(REG_ESCAPE,      16'(esc));
        write_reg(REG_AVOID,       16'(avd));
        cur_vmin = 16'(vmin);
        cur_vmax = 16'(vmax);
    endtask

    // Offer one item after a drawn gap and hold it until the block takes it.
    // With no gap, tvalid simply stays high and only the payload moves.
    task automatic send_item(input logic [1:0] kind, input logic [FIELD_W-1:0] rng_mm,
                             input logic rng_ok, input logic last, input logic moving);
        in_data_t payload;
        int       gap;
        if (tx_run == 0) begin
            tx_run  = $urandom_range(5, 60);
            tx_lazy = ($urandom_range(0, 2) != 0);
        end
        tx_run--;
        gap = (tx_lazy && tx_rush == 0) ? $urandom_range(0, 12) : 0;
        if (tx_rush > 0)
            tx_rush--;
        payload             = '0;
        payload.range_mm    = rng_mm;
        payload.range_valid = rng_ok;
        payload.key_moving  = moving;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering, wait for every result, then let the pipe settle.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Range draw: mostly near the clear and front thresholds so the minima matter,
    // sometimes right at the validity bounds, sometimes anything at all.
    function automatic logic [FIELD_W-1:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return FIELD_W'($urandom_range(0, 65535));
            1:       return cur_vmin + FIELD_W'($urandom_range(0, 2)) - 16'd1;
            2:       return cur_vmax + FIELD_W'($urandom_range(0, 2)) - 16'd1;
            default: return FIELD_W'($urandom_range(150, 2600));
        endcase
    endfunction

    task automatic load_phase(input int phase);
        case (phase)
            0: begin    // stock thresholds, wide angle steps to reach both sides
                load_settings(100, 30000, 1150, 150, -3142, 200, 30, 10);
                tick_burst_max = 40;
            end
            1: begin    // never clear, never front: longest avoid turns, angle wraps
                load_settings(0, 65535, 65535, 0, 3142, 1000, 255, 255);
                tick_burst_max = 260;
            end
            2: begin    // nothing valid: every live scan ends as a front obstacle
                load_settings(65535, 0, 65535, 65535, -3142, 0, 1, 1);
                tick_burst_max = 4;
            end
            6: begin    // exact zero angle and zero-length turns
                load_settings(100, 30000, 1150, 150, -1000, 250, 0, 0);
                tick_burst_max = 5;
            end
            default: begin
                load_settings($urandom_range(0, 400), $urandom_range(1500, 65535),
                              $urandom_range(300, 2100), $urandom_range(0, 800),
                              int'($urandom_range(0, 6284)) - 3142,
                              $urandom_range(0, 1000),
                              $urandom_range(0, 12), $urandom_range(0, 12));
                tick_burst_max = 15;
            end
        endcase
    endtask

    // Random episodes: mostly whole scans with random content, then tick bursts,
    // manual events and a share of noise (any kind, any field, broken scans).
    task automatic run_random(input int count);
        int   target, len, pick, i;
        logic broken, pressed;
        target  = items_sent + count;
        pressed = 1'b0;
        while (items_sent < target) begin
            if (!pressed && items_sent >= target - count / 2) begin
                // fill the block: long result hold-off while items keep coming
                hold_request = 1'b1;
                tx_rush      = 40;
                pressed      = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len    = $urandom_range(1, 40);
                broken = ($urandom_range(0, 9) == 0);
                for (i = 0; i < len; i++)
                    send_item(KIND_SAMPLE, pick_range(), $urandom_range(0, 15) != 0,
                              (i == len - 1) && !broken, 1'b0);
            end else if (pick < 75) begin
                len = $urandom_range(1, tick_burst_max);
                repeat (len)
                    send_item(KIND_TICK, FIELD_W'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom));
            end else if (pick < 85) begin
                // release more often than press so manual mode does not dominate
                send_item(KIND_MANUAL, FIELD_W'($urandom), 1'($urandom), 1'($urandom),
                          $urandom_range(0, 2) == 0);
            end else begin
                send_item(2'($urandom_range(0, 3)), FIELD_W'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        int phase;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_SAMPLE;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_VALID_MIN;
        cfg_data     = '0;
        hold_request = 1'b0;
        items_sent   = 0;
        tx_run       = 0;
        tx_rush      = 0;
        tx_lazy      = 1'b0;
        cur_vmin     = VALID_MIN_RST;
        cur_vmax     = VALID_MAX_RST;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: start -1000 with step 500 puts the third sample of a scan on
        // angle zero. Zero escape ticks end a front turn at once.
        load_settings(100, 30000, 1150, 150, -1000, 500, 0, 2);
        // right obstacle; below-min, zero-angle, all-ones and no-number samples
        send_item(KIND_SAMPLE, 16'd500,   1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd0,     1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd300,   1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'hFFFF,  1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd900,   1'b0, 1'b1, 1'b0);
        // scan while the turn runs is dropped
        send_item(KIND_SAMPLE, 16'd200,   1'b1, 1'b1, 1'b0);
        send_item(KIND_TICK,   16'd0,     1'b0, 1'b0, 1'b0);
        send_item(KIND_TICK,   16'd0,     1'b0, 1'b0, 1'b0);
        send_item(KIND_TICK,   16'd0,     1'b0, 1'b0, 1'b0);  // no turn running
        // left obstacle while avoiding
        send_item(KIND_SAMPLE, 16'd1500,  1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd1400,  1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd100,   1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd600,   1'b1, 1'b1, 1'b0);
        // manual press cancels the turn, scans are ignored, release drives again
        send_item(KIND_MANUAL, 16'd0,     1'b0, 1'b0, 1'b1);
        send_item(KIND_SAMPLE, 16'd700,   1'b1, 1'b1, 1'b0);
        send_item(KIND_MANUAL, 16'd0,     1'b0, 1'b0, 1'b0);
        // front obstacle with a zero-length escape
        send_item(KIND_SAMPLE, 16'd800,   1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd100,   1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd29999, 1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd850,   1'b1, 1'b1, 1'b0);
        // unused kind with every field at its top value
        send_item(KIND_UNUSED, 16'hFFFF,  1'b1, 1'b1, 1'b1);
        send_item(KIND_TICK,   16'd0,     1'b0, 1'b0, 1'b0);
        // single at-max sample: nothing valid, so clear
        send_item(KIND_SAMPLE, 16'd30000, 1'b1, 1'b1, 1'b0);
        quiesce();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            load_phase(phase);
            run_random(PHASE_ITEMS);
            quiesce();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
